### rtl/tdp_pkg.sv
// Shared types and codes for the trial-division primality tester.
// No dependencies; used by front, back and top-level modules.
`default_nettype none
package tdp_pkg;

    localparam int OutDataW = 8;

    typedef enum logic [1:0] {
        KIND_NOT_PRIME = 2'd0,
        KIND_PRIME     = 2'd1,
        KIND_TRIAL     = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DIV   = 4'b0010,
        ST_CHECK = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

endpackage
`default_nettype wire

### rtl/tdp_front.sv
// Front end: accepts input beats and classifies each value.
// Depends on tdp_pkg for the kind codes.
`default_nettype none
module tdp_front #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [VALUE_WIDTH-1:0] i_value,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [VALUE_WIDTH+1:0]      o_entry
);

    logic                   r_valid;
    tdp_pkg::t_kind         r_kind;
    logic [VALUE_WIDTH-1:0] r_value;
    tdp_pkg::t_kind         n_kind;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_entry = {r_kind, r_value};

    always_comb begin
        if (i_value[VALUE_WIDTH-1]) begin
            n_kind = tdp_pkg::KIND_NOT_PRIME;
        end else if (i_value[VALUE_WIDTH-1:1] == '0) begin
            n_kind = tdp_pkg::KIND_NOT_PRIME;
        end else if (i_value == VALUE_WIDTH'(2)) begin
            n_kind = tdp_pkg::KIND_PRIME;
        end else if (!i_value[0]) begin
            n_kind = tdp_pkg::KIND_NOT_PRIME;
        end else begin
            n_kind = tdp_pkg::KIND_TRIAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_kind  <= n_kind;
            r_value <= i_value;
        end
    end

endmodule
`default_nettype wire

### rtl/tdp_queue.sv
// Two-entry queue between the front end and the divider back end.
// No dependencies.
`default_nettype none
module tdp_queue #(
    parameter int WIDTH = 34
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [WIDTH-1:0]      o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             push;
    logic             pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

### rtl/tdp_back.sv
// Back end: trial division by odd divisors with a bit-serial divider,
// plus the output register. Depends on tdp_pkg for kinds and states.
`default_nettype none
module tdp_back #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [VALUE_WIDTH+1:0] i_entry,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic                        o_is_prime
);

    localparam int CntW = $clog2(VALUE_WIDTH);

    tdp_pkg::t_state        r_state;
    logic [VALUE_WIDTH-1:0] r_value;
    logic [VALUE_WIDTH-1:0] r_dvd;
    logic [VALUE_WIDTH-1:0] r_div;
    logic [VALUE_WIDTH-1:0] r_quo;
    logic [VALUE_WIDTH-1:0] r_rem;
    logic [CntW-1:0]        r_cnt;
    logic                   r_result;
    logic                   r_out_valid;
    logic                   r_out_prime;
    tdp_pkg::t_kind         kind;
    logic [VALUE_WIDTH:0]   shifted;
    logic [VALUE_WIDTH:0]   diff;
    logic                   fits;
    logic                   out_free;

    assign kind     = tdp_pkg::t_kind'(i_entry[VALUE_WIDTH+1:VALUE_WIDTH]);
    assign shifted  = {r_rem, r_dvd[VALUE_WIDTH-1]};
    assign diff     = shifted - {1'b0, r_div};
    assign fits     = !diff[VALUE_WIDTH];
    assign out_free = !r_out_valid || i_ready;

    assign o_ready    = (r_state == tdp_pkg::ST_IDLE);
    assign o_valid    = r_out_valid;
    assign o_is_prime = r_out_prime;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tdp_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == tdp_pkg::ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                tdp_pkg::ST_IDLE: begin
                    if (i_valid) begin
                        if (kind == tdp_pkg::KIND_TRIAL) begin
                            r_state <= tdp_pkg::ST_DIV;
                        end else begin
                            r_state <= tdp_pkg::ST_DONE;
                        end
                    end
                end
                tdp_pkg::ST_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= tdp_pkg::ST_CHECK;
                    end
                end
                tdp_pkg::ST_CHECK: begin
                    if (r_div > r_quo || r_rem == '0) begin
                        r_state <= tdp_pkg::ST_DONE;
                    end else begin
                        r_state <= tdp_pkg::ST_DIV;
                    end
                end
                tdp_pkg::ST_DONE: begin
                    if (out_free) begin
                        r_state <= tdp_pkg::ST_IDLE;
                    end
                end
                default: begin
                    r_state <= tdp_pkg::ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            tdp_pkg::ST_IDLE: begin
                r_value  <= i_entry[VALUE_WIDTH-1:0];
                r_dvd    <= i_entry[VALUE_WIDTH-1:0];
                r_div    <= VALUE_WIDTH'(3);
                r_rem    <= '0;
                r_cnt    <= CntW'(VALUE_WIDTH - 1);
                r_result <= (kind == tdp_pkg::KIND_PRIME);
            end
            tdp_pkg::ST_DIV: begin
                r_dvd <= {r_dvd[VALUE_WIDTH-2:0], 1'b0};
                r_quo <= {r_quo[VALUE_WIDTH-2:0], fits};
                r_rem <= fits ? diff[VALUE_WIDTH-1:0] : shifted[VALUE_WIDTH-1:0];
                r_cnt <= r_cnt - CntW'(1);
            end
            tdp_pkg::ST_CHECK: begin
                r_result <= (r_div > r_quo);
                r_div    <= r_div + VALUE_WIDTH'(2);
                r_dvd    <= r_value;
                r_rem    <= '0;
                r_cnt    <= CntW'(VALUE_WIDTH - 1);
            end
            tdp_pkg::ST_DONE: begin
                if (out_free) begin
                    r_out_prime <= r_result;
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/trial_division_primality_test_top.sv
// Top level of the trial-division primality tester.
// Instantiates tdp_front, tdp_queue and tdp_back; uses tdp_pkg.
//
//   channel  dir  tdata bits                       handshake
//   s_axis   in   [VALUE_WIDTH-1:0] value, signed  i_s_axis_tvalid / o_s_axis_tready
//   m_axis   out  [0] is_prime                     o_m_axis_tvalid / i_m_axis_tready
//
// Negative, 0, 1, 2 and even values are classified by the front end and skip the divider.
// Odd values are divided by each odd divisor 3, 5, ... up to isqrt(value) or
// the first factor, using the one-bit-per-cycle divider.
// Synchronous active-low reset clears all valids; the queue holds two items.
// Either side may stall independently; the front keeps accepting until full.
`default_nettype none
module trial_division_primality_test_top #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // [VALUE_WIDTH-1:0] value, rest zero
    input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // [0] is_prime, [7:1] zero
    output logic [tdp_pkg::OutDataW-1:0] o_m_axis_tdata
);

    logic                   fq_valid;
    logic                   fq_ready;
    logic [VALUE_WIDTH+1:0] fq_entry;
    logic                   qb_valid;
    logic                   qb_ready;
    logic [VALUE_WIDTH+1:0] qb_entry;
    logic                   is_prime;

    assign o_m_axis_tdata = {{(tdp_pkg::OutDataW-1){1'b0}}, is_prime};

    tdp_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_value (i_s_axis_tdata[VALUE_WIDTH-1:0]),
        .o_valid (fq_valid),
        .i_ready (fq_ready),
        .o_entry (fq_entry)
    );

    tdp_queue #(.WIDTH(VALUE_WIDTH + 2)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fq_valid),
        .o_ready (fq_ready),
        .i_data  (fq_entry),
        .o_valid (qb_valid),
        .i_ready (qb_ready),
        .o_data  (qb_entry)
    );

    tdp_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (qb_valid),
        .o_ready    (qb_ready),
        .i_entry    (qb_entry),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_is_prime (is_prime)
    );

endmodule
`default_nettype wire

### rtl/tdp_checker.sv
// Port-level checks for the primality tester, bound to the top level.
// Depends on tdp_pkg for the output data width.
`default_nettype none
module tdp_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         o_s_axis_tready,
    input wire logic                         o_m_axis_tvalid,
    input wire logic                         i_m_axis_tready,
    input wire logic [tdp_pkg::OutDataW-1:0] o_m_axis_tdata
);

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_axis_tready && !o_m_axis_tvalid)
        else $error("ports not idle after reset");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[tdp_pkg::OutDataW-1:1] == '0)
        else $error("output padding bits set");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output valid dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("output data changed while stalled");

endmodule

bind trial_division_primality_test_top tdp_checker u_tdp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
`default_nettype wire
